@@ hdl/dual_pair_light_contrast_detector_unit_defines.svh @@
// Assertion macros shared by the contrast detector checkers
`ifndef DUAL_PAIR_LIGHT_CONTRAST_DETECTOR_UNIT_DEFINES_SVH
`define DUAL_PAIR_LIGHT_CONTRAST_DETECTOR_UNIT_DEFINES_SVH

// Check on every rising edge outside reset
`define DPLCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included
`define DPLCD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/dplcd_pkg.sv @@
// Types, constants and register codes of the contrast detector
`default_nettype none
package dplcd_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int FRACTION_BITS = 16;
   localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
   localparam int ALPHA_BITS    = 17;
   localparam int ALPHA_FRAC    = 16;
   localparam int THR_BITS      = 8;
   localparam int PROD_BITS     = AVG_BITS + ALPHA_BITS;
   localparam int CMP_BITS      = AVG_BITS + 1 + THR_BITS;
   localparam int CHANNELS      = 4;
   localparam int STEP_BITS     = $clog2(CHANNELS + 1);
   localparam int PERCENT_SCALE = 200;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE       = ALPHA_BITS'(1 << ALPHA_FRAC);
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET     = ALPHA_BITS'(6554);
   localparam logic [THR_BITS-1:0]   LARGE_THR_RESET = THR_BITS'(165);
   localparam logic [THR_BITS-1:0]   SMALL_THR_RESET = THR_BITS'(155);
   localparam logic [PROD_BITS:0]    ROUND_BIAS      = (PROD_BITS+1)'((1 << ALPHA_FRAC) - 1);

   typedef enum logic [CSR_ADDR_BITS-3:0] {
      REG_ALPHA     = 2'd0,
      REG_LARGE_THR = 2'd1,
      REG_SMALL_THR = 2'd2
   } csr_index_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [AVG_BITS-1:0]    avg_type;

   typedef struct packed {
      sample_type front_large;
      sample_type front_small;
      sample_type back_large;
      sample_type back_small;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [ALPHA_BITS-1:0] alpha;
      logic [THR_BITS-1:0]   large_thr;
      logic [THR_BITS-1:0]   small_thr;
   } cfg_type;

   typedef struct packed {
      logic       detected;
      sample_type front_large;
      sample_type front_small;
      sample_type back_large;
      sample_type back_small;
   } result_type;

endpackage
`default_nettype wire

@@ hdl/dplcd_if.sv @@
// Request and response channel interfaces of the contrast detector
`default_nettype none
interface dplcd_req_if;
   import dplcd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type front_large_sample;
   sample_type front_small_sample;
   sample_type back_large_sample;
   sample_type back_small_sample;

   modport source (output valid, front_large_sample, front_small_sample,
                   back_large_sample, back_small_sample, input ready);
   modport sink   (input valid, front_large_sample, front_small_sample,
                   back_large_sample, back_small_sample, output ready);
endinterface

interface dplcd_rsp_if;
   import dplcd_pkg::*;
   logic       valid;
   logic       ready;
   logic       detected;
   sample_type front_large_level;
   sample_type front_small_level;
   sample_type back_large_level;
   sample_type back_small_level;

   modport source (output valid, detected, front_large_level, front_small_level,
                   back_large_level, back_small_level, input ready);
   modport sink   (input valid, detected, front_large_level, front_small_level,
                   back_large_level, back_small_level, output ready);
endinterface
`default_nettype wire

@@ hdl/dual_pair_light_contrast_detector_unit.sv @@
// Top level of the dual-pair light contrast detector
//
//   channel   direction  transfer when         carries
//   req_chan  in         valid && ready       four 10-bit light samples
//   rsp_chan  out        valid && ready       detect flag, four 10-bit levels
//   csr_*     in/out     psel && penable      alpha and two thresholds
//
// In the back end an item is pulled from the queue in IDLE, passes through
// the single alpha multiplier in SMOOTH (one channel per cycle, the update of
// each channel overlapped with the product of the next), has its threshold
// products formed in PRODUCT and is loaded into the output register in DECIDE.
// Reset is synchronous; it clears the averages and loads the register defaults.
// A two-entry queue keeps the request side open while the back end works;
// the back end holds its last step while the output register waits.
`default_nettype none
module dual_pair_light_contrast_detector_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   dplcd_req_if.sink                                req_chan,
   dplcd_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dplcd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [dplcd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [dplcd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import dplcd_pkg::*;

   cfg_type  cfg;
   head_type head;
   logic     pop;

   // register file; alpha leaves already saturated at one
   dplcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // intake: take each transfer into the queue
   dplcd_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   // back end: advance the averages, test both pairs, drive the result
   dplcd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .cfg   (cfg),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
`default_nettype wire

@@ hdl/dplcd_csr.sv @@
// Configuration registers with APB-style access and alpha saturation
`default_nettype none
module dplcd_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dplcd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [dplcd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [dplcd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                     csr_pready,
   output dplcd_pkg::cfg_type                       cfg
);
   import dplcd_pkg::*;

   logic [ALPHA_BITS-1:0] alpha_ff;
   logic [THR_BITS-1:0]   large_thr_ff;
   logic [THR_BITS-1:0]   small_thr_ff;
   logic                  write;
   csr_index_type         index;

   assign csr_pready = 1'b1;
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         large_thr_ff <= LARGE_THR_RESET;
         small_thr_ff <= SMALL_THR_RESET;
      end else if (write) begin
         case (index)
            REG_ALPHA:     alpha_ff     <= csr_pwdata[ALPHA_BITS-1:0];
            REG_LARGE_THR: large_thr_ff <= csr_pwdata[THR_BITS-1:0];
            REG_SMALL_THR: small_thr_ff <= csr_pwdata[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ALPHA:     csr_prdata = CSR_DATA_BITS'(alpha_ff);
         REG_LARGE_THR: csr_prdata = CSR_DATA_BITS'(large_thr_ff);
         REG_SMALL_THR: csr_prdata = CSR_DATA_BITS'(small_thr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // saturate alpha at one so the average never overshoots the sample
   assign cfg.alpha     = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign cfg.large_thr = large_thr_ff;
   assign cfg.small_thr = small_thr_ff;

endmodule
`default_nettype wire

@@ hdl/dplcd_front.sv @@
// Intake stage: accept sample sets into a short queue for the back end
`default_nettype none
module dplcd_front (
   input  wire logic          clock,
   input  wire logic          reset,
   dplcd_req_if.sink          req,
   input  wire logic          pop,
   output dplcd_pkg::head_type head
);
   import dplcd_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push;
   logic                   take;
   item_type               incoming;

   assign req.ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign take      = pop && (count_ff != '0);

   assign incoming.front_large = req.front_large_sample;
   assign incoming.front_small = req.front_small_sample;
   assign incoming.back_large  = req.back_large_sample;
   assign incoming.back_small  = req.back_small_sample;

   always_comb begin
      wr_ptr_in = push ? QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = QCNT_BITS'(count_ff + 1'b1);
      end else if (take && !push) begin
         count_in = QCNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

@@ hdl/dplcd_back.sv @@
// Execution stage: shared-multiplier smoothing, contrast test, result register
`default_nettype none
module dplcd_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  dplcd_pkg::head_type head,
   input  dplcd_pkg::cfg_type  cfg,
   output logic                pop,
   dplcd_rsp_if.source         rsp
);
   import dplcd_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SMOOTH,
      PRODUCT,
      DECIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   avg_type                avg_ff [CHANNELS];
   avg_type                avg_in [CHANNELS];
   sample_type             samp_ff [CHANNELS];
   sample_type             samp_in [CHANNELS];
   avg_type                hold_ff, hold_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                   down_ff, down_in;
   logic [CMP_BITS-1:0]    large_lhs_ff, large_lhs_in;
   logic [CMP_BITS-1:0]    large_rhs_ff, large_rhs_in;
   logic [CMP_BITS-1:0]    small_lhs_ff, small_lhs_in;
   logic [CMP_BITS-1:0]    small_rhs_ff, small_rhs_in;
   logic                   large_pos_ff, large_pos_in;
   logic                   small_pos_ff, small_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   avg_type                sample_pt;
   avg_type                mag;
   logic                   below;
   logic [PROD_BITS:0]     rounded;
   avg_type                delta;
   avg_type                updated;

   // multiplier operand: head channel of the rotating line
   always_comb begin
      sample_pt = {samp_ff[0], FRACTION_BITS'(0)};
      below     = sample_pt < avg_ff[0];
      mag       = below ? avg_ff[0] - sample_pt : sample_pt - avg_ff[0];
   end

   // update of the channel multiplied in the previous cycle; round down towards minus infinity
   always_comb begin
      rounded = {1'b0, prod_ff} + (down_ff ? ROUND_BIAS : '0);
      delta   = rounded[ALPHA_FRAC +: AVG_BITS];
      updated = down_ff ? hold_ff - delta : hold_ff + delta;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      avg_in       = avg_ff;
      samp_in      = samp_ff;
      hold_in      = hold_ff;
      prod_in      = prod_ff;
      down_in      = down_ff;
      large_lhs_in = large_lhs_ff;
      large_rhs_in = large_rhs_ff;
      small_lhs_in = small_lhs_ff;
      small_rhs_in = small_rhs_ff;
      large_pos_in = large_pos_ff;
      small_pos_in = small_pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop          = 1'b0;

      case (state_ff)
         IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               samp_in[0] = head.item.front_large;
               samp_in[1] = head.item.front_small;
               samp_in[2] = head.item.back_large;
               samp_in[3] = head.item.back_small;
               step_in    = '0;
               state_in   = SMOOTH;
            end
         end
         SMOOTH: begin
            // multiply the head channel, write back the previous one at the tail
            prod_in = PROD_BITS'(mag) * PROD_BITS'(cfg.alpha);
            down_in = below;
            hold_in = avg_ff[0];
            for (int i = 0; i < CHANNELS - 1; i++) begin
               avg_in[i]  = avg_ff[i+1];
               samp_in[i] = samp_ff[i+1];
            end
            avg_in[CHANNELS-1]  = updated;
            samp_in[CHANNELS-1] = samp_ff[0];
            step_in = STEP_BITS'(step_ff + 1'b1);
            if (step_ff == STEP_BITS'(CHANNELS)) begin
               state_in = PRODUCT;
            end
         end
         PRODUCT: begin
            // 200*(f-b) against T*(f+b) for each pair
            large_pos_in = avg_ff[0] > avg_ff[2];
            small_pos_in = avg_ff[1] > avg_ff[3];
            large_lhs_in = CMP_BITS'(avg_ff[0] - avg_ff[2]) * CMP_BITS'(PERCENT_SCALE);
            small_lhs_in = CMP_BITS'(avg_ff[1] - avg_ff[3]) * CMP_BITS'(PERCENT_SCALE);
            large_rhs_in = CMP_BITS'(cfg.large_thr)
                         * CMP_BITS'({1'b0, avg_ff[0]} + {1'b0, avg_ff[2]});
            small_rhs_in = CMP_BITS'(cfg.small_thr)
                         * CMP_BITS'({1'b0, avg_ff[1]} + {1'b0, avg_ff[3]});
            state_in = DECIDE;
         end
         DECIDE: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.detected    = large_pos_ff && (large_lhs_ff > large_rhs_ff)
                                 && small_pos_ff && (small_lhs_ff > small_rhs_ff);
               rsp_in.front_large = avg_ff[0][FRACTION_BITS +: SAMPLE_BITS];
               rsp_in.front_small = avg_ff[1][FRACTION_BITS +: SAMPLE_BITS];
               rsp_in.back_large  = avg_ff[2][FRACTION_BITS +: SAMPLE_BITS];
               rsp_in.back_small  = avg_ff[3][FRACTION_BITS +: SAMPLE_BITS];
               state_in           = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         avg_ff       <= avg_in;
      end
      samp_ff      <= samp_in;
      hold_ff      <= hold_in;
      prod_ff      <= prod_in;
      down_ff      <= down_in;
      large_lhs_ff <= large_lhs_in;
      large_rhs_ff <= large_rhs_in;
      small_lhs_ff <= small_lhs_in;
      small_rhs_ff <= small_rhs_in;
      large_pos_ff <= large_pos_in;
      small_pos_ff <= small_pos_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.detected          = rsp_ff.detected;
   assign rsp.front_large_level = rsp_ff.front_large;
   assign rsp.front_small_level = rsp_ff.front_small;
   assign rsp.back_large_level  = rsp_ff.back_large;
   assign rsp.back_small_level  = rsp_ff.back_small;

endmodule
`default_nettype wire

@@ hdl/dplcd_checker.sv @@
// Port-level checks of the contrast detector and their binding
`default_nettype none
`include "dual_pair_light_contrast_detector_unit_defines.svh"
module dplcd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_detected,
   input wire dplcd_pkg::sample_type front_large_level,
   input wire dplcd_pkg::sample_type front_small_level,
   input wire dplcd_pkg::sample_type back_large_level,
   input wire dplcd_pkg::sample_type back_small_level
);
   import dplcd_pkg::*;

   result_type rsp_payload;

   assign rsp_payload = {rsp_detected, front_large_level, front_small_level,
                         back_large_level, back_small_level};

   `DPLCD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `DPLCD_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "response changed while stalled")
   `DPLCD_ASSERT(a_det_order, rsp_valid && rsp_detected |-> (front_large_level >= back_large_level) && (front_small_level >= back_small_level), "detection without brighter front")
   `DPLCD_ASSERT_RST(a_rsp_reset, $past(reset) |-> !rsp_valid, "response valid straight after reset")
   `DPLCD_ASSERT_RST(a_req_reset, $past(reset) |-> req_ready, "queue not open after reset")

endmodule

bind dual_pair_light_contrast_detector_unit dplcd_checker u_dplcd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_detected      (rsp_chan.detected),
   .front_large_level (rsp_chan.front_large_level),
   .front_small_level (rsp_chan.front_small_level),
   .back_large_level  (rsp_chan.back_large_level),
   .back_small_level  (rsp_chan.back_small_level)
);
`default_nettype wire

@@ tb/tb_dual_pair_light_contrast_detector_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the dual-pair light contrast detector top level
module tb_dual_pair_light_contrast_detector_unit;
   import dplcd_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 9;
   localparam int PIPE_LATENCY    = 8;     // back-end settling wait in wait_idle
   localparam int IDLE_LIMIT      = 4000;  // cycles without any transfer before giving up
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off to fill the block
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 104;
   localparam int INDEX_UNUSED    = 3;     // register index with nothing behind it
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

   typedef enum int {
      MODE_UNIFORM,
      MODE_FRONT_BRIGHT,
      MODE_BACK_BRIGHT,
      MODE_BALANCED
   } sample_mode_type;

   logic clock;
   logic reset;

   dplcd_req_if req_chan ();
   dplcd_rsp_if rsp_chan ();

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   dual_pair_light_contrast_detector_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: running averages in item order and the register copies
   avg_type               ema_level [CHANNELS];
   logic [ALPHA_BITS-1:0] alpha_cfg;
   logic [THR_BITS-1:0]   large_thr_cfg;
   logic [THR_BITS-1:0]   small_thr_cfg;

   item_type   pending_items[$];
   result_type expected_results[$];

   // Traffic shaping, set by the main sequence between phases
   int unsigned max_gap;
   int unsigned max_burst;
   int unsigned ready_pct;
   bit          hold_request;
   bit          req_taken;
   int unsigned error_count;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // One step of the exponential average; the fall rounds towards minus infinity
   function automatic avg_type ema_update(avg_type level, sample_type sample,
                                          logic [ALPHA_BITS-1:0] alpha);
      logic [63:0] weight;
      logic [63:0] target;
      logic [63:0] acc;
      logic [63:0] delta;
      weight = (alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha);
      target = 64'(sample) << FRACTION_BITS;
      acc    = 64'(level);
      if (target >= acc) begin
         delta = ((target - acc) * weight) >> ALPHA_FRAC;
         acc   = acc + delta;
      end else begin
         delta = ((acc - target) * weight + ((64'd1 << ALPHA_FRAC) - 1)) >> ALPHA_FRAC;
         acc   = acc - delta;
      end
      return avg_type'(acc);
   endfunction

   // Division-free percent test: 200*(f-b) > T*(f+b), never on a zero sum
   function automatic logic contrast_exceeds(avg_type front, avg_type back,
                                             logic [THR_BITS-1:0] thr);
      logic [63:0] total;
      total = 64'(front) + 64'(back);
      if (total == 64'd0 || front <= back)
         return 1'b0;
      return (64'(PERCENT_SCALE) * (64'(front) - 64'(back))) > (64'(thr) * total);
   endfunction

   // Advance the averages by one item and form the detector output
   function automatic result_type predict_detection(item_type item);
      sample_type samples [CHANNELS];
      result_type res;
      samples = '{item.front_large, item.front_small, item.back_large, item.back_small};
      for (int i = 0; i < CHANNELS; i++)
         ema_level[i] = ema_update(ema_level[i], samples[i], alpha_cfg);
      res.detected    = contrast_exceeds(ema_level[0], ema_level[2], large_thr_cfg) &&
                        contrast_exceeds(ema_level[1], ema_level[3], small_thr_cfg);
      res.front_large = ema_level[0][AVG_BITS-1:FRACTION_BITS];
      res.front_small = ema_level[1][AVG_BITS-1:FRACTION_BITS];
      res.back_large  = ema_level[2][AVG_BITS-1:FRACTION_BITS];
      res.back_small  = ema_level[3][AVG_BITS-1:FRACTION_BITS];
      return res;
   endfunction

   function automatic sample_type pick_sample(int unsigned lo, int unsigned hi);
      return sample_type'($urandom_range(lo, hi));
   endfunction

   // Contrasting runs drive the averages apart; uniform items are the noise
   function automatic item_type make_item(sample_mode_type mode);
      item_type item;
      case (mode)
         MODE_FRONT_BRIGHT: begin
            item.front_large = pick_sample(512, SAMPLE_MAX);
            item.front_small = pick_sample(512, SAMPLE_MAX);
            item.back_large  = pick_sample(0, 256);
            item.back_small  = pick_sample(0, 256);
         end
         MODE_BACK_BRIGHT: begin
            item.front_large = pick_sample(0, 256);
            item.front_small = pick_sample(0, 256);
            item.back_large  = pick_sample(512, SAMPLE_MAX);
            item.back_small  = pick_sample(512, SAMPLE_MAX);
         end
         MODE_BALANCED: begin
            item.front_large = pick_sample(0, SAMPLE_MAX);
            item.front_small = pick_sample(0, SAMPLE_MAX);
            item.back_large  = item.front_large;
            item.back_small  = item.front_small ^ sample_type'($urandom_range(0, 3));
         end
         default: begin
            item = item_type'($urandom);
            item.back_small = pick_sample(0, SAMPLE_MAX);
         end
      endcase
      return item;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // APB write: setup, access, then update the register copy at the transfer edge
   task automatic csr_write(input int index, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(index * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_ALPHA:     alpha_cfg     = value[ALPHA_BITS-1:0];
         REG_LARGE_THR: large_thr_cfg = value[THR_BITS-1:0];
         REG_SMALL_THR: small_thr_cfg = value[THR_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Hold until every item is sent and answered, then let the back end settle;
   // test at the rising edge, where the sender never moves
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic logic [ALPHA_BITS-1:0] choose_alpha();
      case ($urandom_range(0, 7))
         0:       return ALPHA_BITS'(1);
         1:       return ALPHA_ONE;
         2, 3:    return ALPHA_BITS'($urandom_range(16384, 65535));
         4, 5:    return ALPHA_BITS'($urandom_range(1000, 16383));
         6:       return ALPHA_BITS'($urandom_range(65537, 131071));
         default: return '0;
      endcase
   endfunction

   function automatic logic [THR_BITS-1:0] choose_threshold();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return THR_BITS'(PERCENT_SCALE);
         2:       return THR_BITS'($urandom_range(201, 255));
         default: return THR_BITS'($urandom_range(0, 200));
      endcase
   endfunction

   // Sender: bursts of random length, random gaps; hold each item until its transfer
   always @(negedge clock) begin : req_driver
      int unsigned burst_left;
      int unsigned gap_left;
      logic        valid_next;
      item_type    item;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_chan.valid || req_taken) begin
         req_taken  = 1'b0;
         valid_next = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() != 0) begin
            item = pending_items.pop_front();
            req_chan.front_large_sample <= item.front_large;
            req_chan.front_small_sample <= item.front_small;
            req_chan.back_large_sample  <= item.back_large;
            req_chan.back_small_sample  <= item.back_small;
            valid_next = 1'b1;
            if (burst_left == 0)
               burst_left = $urandom_range(1, max_burst);
            burst_left--;
            if (burst_left == 0)
               gap_left = $urandom_range(0, max_gap);
         end
         req_chan.valid <= valid_next;
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here on request
   always @(negedge clock) begin : rsp_driver
      int unsigned hold_left;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // Monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin : transfer_monitor
      result_type got;
      result_type want;
      bit         moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(predict_detection('{
               front_large: req_chan.front_large_sample,
               front_small: req_chan.front_small_sample,
               back_large:  req_chan.back_large_sample,
               back_small:  req_chan.back_small_sample}));
            req_taken = 1'b1;
            moved     = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            got.detected    = rsp_chan.detected;
            got.front_large = rsp_chan.front_large_level;
            got.front_small = rsp_chan.front_small_level;
            got.back_large  = rsp_chan.back_large_level;
            got.back_small  = rsp_chan.back_small_level;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, pending count", 0, 1);
            end else begin
               want = expected_results.pop_front();
               if (got.detected !== want.detected)
                  report_mismatch("detected", want.detected, got.detected);
               if (got.front_large !== want.front_large)
                  report_mismatch("front_large_level", want.front_large, got.front_large);
               if (got.front_small !== want.front_small)
                  report_mismatch("front_small_level", want.front_small, got.front_small);
               if (got.back_large !== want.back_large)
                  report_mismatch("back_large_level", want.back_large, got.back_large);
               if (got.back_small !== want.back_small)
                  report_mismatch("back_small_level", want.back_small, got.back_small);
            end
         end
         if (csr_psel && csr_penable && csr_pready)
            moved = 1'b1;
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d results still expected", expected_results.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : main_sequence
      int unsigned     n;
      int unsigned     run;
      sample_mode_type mode;
      int unsigned     pick;

      // Drive every input to a known value before the first edge
      reset                       = 1'b1;
      req_chan.valid              = 1'b0;
      req_chan.front_large_sample = '0;
      req_chan.front_small_sample = '0;
      req_chan.back_large_sample  = '0;
      req_chan.back_small_sample  = '0;
      rsp_chan.ready              = 1'b0;
      csr_psel                    = 1'b0;
      csr_penable                 = 1'b0;
      csr_pwrite                  = 1'b0;
      csr_paddr                   = '0;
      csr_pwdata                  = '0;
      for (int i = 0; i < CHANNELS; i++)
         ema_level[i] = '0;
      alpha_cfg     = ALPHA_RESET;
      large_thr_cfg = LARGE_THR_RESET;
      small_thr_cfg = SMALL_THR_RESET;
      max_gap       = 3;
      max_burst     = 4;
      ready_pct     = 70;
      hold_request  = 1'b0;
      req_taken     = 1'b0;
      error_count   = 0;
      idle_cycles   = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: register defaults, extremes and alternating bit patterns
      pending_items.push_back(item_type'{10'd0, 10'd0, 10'd0, 10'd0});
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF});
      pending_items.push_back(item_type'{10'h2AA, 10'h155, 10'h155, 10'h2AA});
      wait_idle();

      // Alpha of one: each average takes the sample, so contrasts are exact
      csr_write(REG_ALPHA, CSR_DATA_BITS'(ALPHA_ONE));
      csr_write(REG_LARGE_THR, CSR_DATA_BITS'(LARGE_THR_RESET));
      csr_write(REG_SMALL_THR, CSR_DATA_BITS'(SMALL_THR_RESET));
      pending_items.push_back(item_type'{10'd0, 10'd0, 10'd0, 10'd0});       // zero sums
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'd0, 10'd0});
      pending_items.push_back(item_type'{10'd0, 10'd0, 10'h3FF, 10'h3FF});
      pending_items.push_back(item_type'{10'h3FF, 10'd0, 10'd0, 10'd0});     // small pair empty
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'd100, 10'd100});
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'd1, 10'd1});
      pending_items.push_back(item_type'{10'h155, 10'h2AA, 10'h2AA, 10'h155});
      wait_idle();

      // Alpha zero: averages hold their value and ignore whatever arrives
      csr_write(REG_ALPHA, '0);
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF});
      pending_items.push_back(item_type'{10'd0, 10'd0, 10'd0, 10'd0});
      wait_idle();

      // Alpha above one saturates; thresholds at and above the percent ceiling
      csr_write(REG_ALPHA, CSR_DATA_BITS'(ALPHA_BITS'('1)));
      csr_write(REG_LARGE_THR, CSR_DATA_BITS'(PERCENT_SCALE));
      csr_write(REG_SMALL_THR, CSR_DATA_BITS'(8'hFF));
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'd0, 10'd0});
      pending_items.push_back(item_type'{10'd500, 10'd500, 10'd0, 10'd0});
      wait_idle();

      // Write to an unused index must be dropped; zero thresholds, half alpha
      csr_write(INDEX_UNUSED, 32'hFFFF_FFFF);
      csr_write(REG_ALPHA, CSR_DATA_BITS'(32768));
      csr_write(REG_LARGE_THR, '0);
      csr_write(REG_SMALL_THR, '0);
      pending_items.push_back(item_type'{10'd512, 10'd512, 10'd511, 10'd511});
      pending_items.push_back(item_type'{10'd0, 10'd0, 10'd0, 10'd0});
      pending_items.push_back(item_type'{10'd1, 10'd1, 10'd0, 10'd0});
      pending_items.push_back(item_type'{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FE});
      wait_idle();

      // Random phases: new settings each time, junk in unused data bits
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               max_gap   = 0;
               max_burst = 1;
               ready_pct = 100;
            end
            1: begin
               // Stall the output for a long stretch while items keep coming
               max_gap      = 0;
               max_burst    = 1;
               ready_pct    = 100;
               hold_request = 1'b1;
            end
            default: begin
               max_gap   = $urandom_range(1, 16);
               max_burst = $urandom_range(1, 12);
               ready_pct = $urandom_range(25, 95);
            end
         endcase
         csr_write(REG_ALPHA, ($urandom & ~32'h1FFFF) | CSR_DATA_BITS'(choose_alpha()));
         csr_write(REG_LARGE_THR, ($urandom & ~32'hFF) | CSR_DATA_BITS'(choose_threshold()));
         csr_write(REG_SMALL_THR, ($urandom & ~32'hFF) | CSR_DATA_BITS'(choose_threshold()));
         n = 0;
         while (n < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
               mode = MODE_FRONT_BRIGHT;
            else if (pick < 7)
               mode = MODE_UNIFORM;
            else if (pick < 8)
               mode = MODE_BACK_BRIGHT;
            else
               mode = MODE_BALANCED;
            run = $urandom_range(4, 24);
            for (int k = 0; k < run && n < PHASE_ITEMS; k++) begin
               pending_items.push_back(make_item(mode));
               n++;
            end
         end
         wait_idle();
      end

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dplcd_pkg.sv
hdl/dplcd_if.sv
hdl/dplcd_csr.sv
hdl/dplcd_front.sv
hdl/dplcd_back.sv
hdl/dual_pair_light_contrast_detector_unit.sv
hdl/dplcd_checker.sv
tb/tb_dual_pair_light_contrast_detector_unit.sv
